FILE: src/spq_pkg.sv
// Package for the sorted priority queue: sizes, operation codes and the
// types passed between the top level and the chain of cells. No dependencies.
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int PRIO_W   = 16;
    localparam int VALUE_W  = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic [PRIO_W-1:0]  t_prio;
    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CNT_W-1:0]   t_count;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_value value;
        t_prio  prio;
    } t_entry;

    // Broadcast to every cell: what the chain does this cycle and the new entry.
    typedef struct packed {
        t_cell_op op;
        t_entry   entry;
    } t_cell_ctrl;

endpackage

FILE: src/spq_cell.sv
// One cell of the sorted chain: holds one entry and takes its next entry
// from itself, the new item, or a neighbor. Depends on spq_pkg.
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occ,
    input  logic                i_left_ge,
    input  spq_pkg::t_entry     i_left,
    input  spq_pkg::t_entry     i_right,
    output logic                o_ge,
    output spq_pkg::t_entry     o_entry
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Held entry ranks at or ahead of the new one; this prefix stays in place.
    assign o_ge    = i_occ && (r_entry.prio >= i_ctrl.entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            spq_pkg::CELL_PUSH: begin
                if (!i_left_ge) begin
                    n_entry = i_left;
                end else if (!o_ge) begin
                    n_entry = i_ctrl.entry;
                end
            end
            spq_pkg::CELL_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted priority queue: a chain of CAPACITY cells kept in descending priority.
// The result is registered when an item is taken and shows on the master side in the next cycle.
// Throughput: one item per cycle unless the input is stalled; the cells take their next entries in that same cycle.
// Input is stalled only while a result waits and the master side is not ready.
// Reset clears the entry count and the output valid; cell contents are not cleared.
module sorted_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // item_value[7:0], item_priority[23:8]
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // out_value[7:0], out_priority[23:8],
                                    // occupancy[28:24], zero[31:29]
    output logic        o_m_tuser   // success[0]
);

    localparam int N = spq_pkg::CAPACITY;

    spq_pkg::t_count     r_count;
    spq_pkg::t_count     n_count;
    logic                r_out_valid;
    logic                r_success;
    logic                n_success;
    spq_pkg::t_entry     r_out_entry;
    spq_pkg::t_entry     n_out_entry;
    spq_pkg::t_cell_ctrl w_ctrl;
    spq_pkg::t_mode      w_mode;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;

    spq_pkg::t_entry     w_entry [N];
    logic                w_ge    [N];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_mode     = spq_pkg::t_mode'(i_s_tuser);
    assign w_full     = (r_count == spq_pkg::t_count'(N));
    assign w_empty    = (r_count == '0);

    always_comb begin
        w_ctrl.op          = spq_pkg::CELL_HOLD;
        w_ctrl.entry.value = i_s_tdata[7:0];
        w_ctrl.entry.prio  = spq_pkg::t_prio'(i_s_tdata[23:8]);
        n_count            = r_count;
        n_success          = 1'b0;
        n_out_entry        = '0;
        if (w_accept) begin
            case (w_mode)
                spq_pkg::MODE_PUSH: begin
                    if (!w_full) begin
                        w_ctrl.op = spq_pkg::CELL_PUSH;
                        n_count   = r_count + 1'b1;
                        n_success = 1'b1;
                    end
                end
                spq_pkg::MODE_POP: begin
                    if (!w_empty) begin
                        w_ctrl.op   = spq_pkg::CELL_POP;
                        n_count     = r_count - 1'b1;
                        n_success   = 1'b1;
                        n_out_entry = w_entry[0];
                    end
                end
                spq_pkg::MODE_CLEAR: begin
                    n_count   = '0;
                    n_success = !w_empty;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl),
            .i_occ     (spq_pkg::t_count'(g) < r_count),
            .i_left_ge ((g == 0) ? 1'b1 : w_ge[(g == 0) ? 0 : g - 1]),
            .i_left    (w_entry[(g == 0) ? 0 : g - 1]),
            .i_right   (w_entry[(g == N - 1) ? g : g + 1]),
            .o_ge      (w_ge[g]),
            .o_entry   (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_success   <= n_success;
            r_out_entry <= n_out_entry;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_success;
    assign o_m_tdata  = {3'b000, 5'(r_count), 16'(r_out_entry.prio), r_out_entry.value};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the sorted priority queue: random stream traffic on both sides,
// checked item by item against a behavioral queue kept here. Needs spq_pkg.
module tb_top;

    // The mode field has one code the block does not use; it must do nothing.
    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam int TARGET_ITEMS = 600;

    typedef struct {
        logic [1:0]      mode;
        spq_pkg::t_value value;
        spq_pkg::t_prio  prio;
    } t_queue_op;

    typedef struct {
        logic            ok;
        spq_pkg::t_value value;
        spq_pkg::t_prio  prio;
        spq_pkg::t_count occ;
    } t_queue_reply;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // item_value[7:0], item_priority[23:8]
    logic [1:0]  i_s_tuser  = '0;   // mode[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;         // out_value[7:0], out_priority[23:8],
                                    // occupancy[28:24], zero[31:29]
    logic        o_m_tuser;         // success[0]

    t_queue_op    ops_to_send[$];
    t_queue_reply awaited_replies[$];

    // Shadow copy of the queue contents, highest priority at index 0.
    spq_pkg::t_value held_value[spq_pkg::CAPACITY];
    spq_pkg::t_prio  held_prio[spq_pkg::CAPACITY];
    int              held_count = 0;

    int  errors = 0;
    int  n_replies = 0, n_push_ok = 0, n_push_full = 0, n_pop_ok = 0, n_pop_empty = 0;
    int  n_clear = 0, n_nop = 0, peak_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    logic no_idle = 1'b0;

    sorted_priority_queue uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Alternates windows of random idling with windows where neither side pauses.
    initial begin
        forever begin
            no_idle <= 1'b0;
            repeat ($urandom_range(60, 400)) @(posedge i_clk);
            no_idle <= 1'b1;
            repeat ($urandom_range(30, 150)) @(posedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_queue_reply apply_queue_op(logic [1:0] mode,
                                                    spq_pkg::t_value value,
                                                    spq_pkg::t_prio prio);
        t_queue_reply reply;
        int pos;
        reply.ok    = 1'b0;
        reply.value = '0;
        reply.prio  = '0;
        case (mode)
            spq_pkg::MODE_PUSH: begin
                if (held_count < spq_pkg::CAPACITY) begin
                    // A new entry goes behind every entry of equal or higher priority.
                    pos = 0;
                    while (pos < held_count && held_prio[pos] >= prio)
                        pos++;
                    for (int k = held_count; k > pos; k--) begin
                        held_value[k] = held_value[k-1];
                        held_prio[k]  = held_prio[k-1];
                    end
                    held_value[pos] = value;
                    held_prio[pos]  = prio;
                    held_count++;
                    reply.ok = 1'b1;
                    n_push_ok++;
                end else begin
                    n_push_full++;
                end
            end
            spq_pkg::MODE_POP: begin
                if (held_count > 0) begin
                    reply.ok    = 1'b1;
                    reply.value = held_value[0];
                    reply.prio  = held_prio[0];
                    for (int k = 1; k < held_count; k++) begin
                        held_value[k-1] = held_value[k];
                        held_prio[k-1]  = held_prio[k];
                    end
                    held_count--;
                    n_pop_ok++;
                end else begin
                    n_pop_empty++;
                end
            end
            spq_pkg::MODE_CLEAR: begin
                reply.ok   = (held_count != 0);
                held_count = 0;
                n_clear++;
            end
            default: begin
                n_nop++;
            end
        endcase
        if (held_count > peak_count)
            peak_count = held_count;
        reply.occ = spq_pkg::t_count'(held_count);
        return reply;
    endfunction

    function automatic spq_pkg::t_prio pick_prio();
        spq_pkg::t_prio tie_pool[4] = '{16'h0000, 16'h0001, 16'h7FFF, 16'hFFFF};
        if ($urandom_range(0, 9) < 4)
            return tie_pool[$urandom_range(0, 3)];
        return spq_pkg::t_prio'($urandom_range(0, 65535));
    endfunction

    function automatic void add_op(logic [1:0] mode, spq_pkg::t_value value,
                                   spq_pkg::t_prio prio);
        t_queue_op op;
        op.mode  = mode;
        op.value = value;
        op.prio  = prio;
        ops_to_send.push_back(op);
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Stimulus side: presents queued items, recording the reply each accepted one implies.
    always @(posedge i_clk) begin : driver
        t_queue_op nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                awaited_replies.push_back(apply_queue_op(i_s_tuser, i_s_tdata[7:0],
                                                         i_s_tdata[23:8]));
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0 || ops_to_send.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                    if (send_gap > 0)
                        send_gap <= send_gap - 1;
                end else begin
                    nxt = ops_to_send.pop_front();
                    i_s_tdata  <= {nxt.prio, nxt.value};
                    i_s_tuser  <= nxt.mode;
                    i_s_tvalid <= 1'b1;
                    send_gap   <= pick_gap();
                end
            end
        end
    end

    // Result side: random back-pressure and a field-by-field compare of every reply.
    always @(posedge i_clk) begin : monitor
        t_queue_reply want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (awaited_replies.size() == 0) begin
                    $error("result item 0x%0h with no reply outstanding", o_m_tdata);
                    errors++;
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("success", want.ok, o_m_tuser);
                    check_field("out_value", want.value, o_m_tdata[7:0]);
                    check_field("out_priority", want.prio, o_m_tdata[23:8]);
                    check_field("occupancy", want.occ, o_m_tdata[28:24]);
                    check_field("padding", 0, o_m_tdata[31:29]);
                    n_replies++;
                end
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    stall_left <= pick_gap();
            end
        end
    end

    initial begin : stimulus
        int counted;
        int seg_len;
        int push_pct;
        int r;

        // Directed: every operation on an empty queue, then fill to capacity with
        // both priority extremes and a run of ties, then overflow, then drain.
        add_op(spq_pkg::MODE_POP, 8'h11, 16'h1111);
        add_op(spq_pkg::MODE_CLEAR, 8'h22, 16'h2222);
        add_op(MODE_NOP, 8'hFF, 16'hFFFF);
        for (int k = 0; k < spq_pkg::CAPACITY; k++) begin
            if (k == 0)
                add_op(spq_pkg::MODE_PUSH, 8'h00, 16'h0000);
            else if (k == 1)
                add_op(spq_pkg::MODE_PUSH, 8'hFF, 16'hFFFF);
            else if (k < 6)
                add_op(spq_pkg::MODE_PUSH, spq_pkg::t_value'(8'hA0 + k), 16'h8000);
            else
                add_op(spq_pkg::MODE_PUSH, spq_pkg::t_value'($urandom_range(0, 255)),
                       pick_prio());
        end
        add_op(spq_pkg::MODE_PUSH, 8'h5A, 16'hFFFF);
        add_op(MODE_NOP, 8'h00, 16'h0000);
        add_op(spq_pkg::MODE_POP, 8'h00, 16'h0000);
        add_op(spq_pkg::MODE_CLEAR, 8'h00, 16'h0000);

        // Random: segments that lean toward filling, draining or holding steady,
        // so occupancy sweeps the whole range, including full and empty.
        counted = 0;
        while (counted < TARGET_ITEMS) begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 50;
                default: push_pct = 20;
            endcase
            repeat (seg_len) begin
                r = $urandom_range(0, 99);
                if (r < 2) begin
                    add_op(MODE_NOP, spq_pkg::t_value'($urandom_range(0, 255)),
                           pick_prio());
                end else begin
                    if (r < 5)
                        add_op(spq_pkg::MODE_CLEAR,
                               spq_pkg::t_value'($urandom_range(0, 255)), pick_prio());
                    else if (r < 5 + push_pct * 95 / 100)
                        add_op(spq_pkg::MODE_PUSH,
                               spq_pkg::t_value'($urandom_range(0, 255)), pick_prio());
                    else
                        add_op(spq_pkg::MODE_POP,
                               spq_pkg::t_value'($urandom_range(0, 255)), pick_prio());
                    counted++;
                end
            end
        end

        wait (i_rst_n);
        wait (ops_to_send.size() == 0);
        @(posedge i_clk);
        wait (!i_s_tvalid);
        wait (awaited_replies.size() == 0);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d replies: %0d pushes (%0d refused when full), %0d pops %s",
                 n_replies, n_push_ok + n_push_full, n_push_full,
                 n_pop_ok + n_pop_empty, $sformatf("(%0d on empty),", n_pop_empty));
        $display("%0d clears, %0d unused-mode items; peak occupancy %0d of %0d.",
                 n_clear, n_nop, peak_count, spq_pkg::CAPACITY);
        if (errors == 0)
            $display("[sorted_priority_queue] OK");
        else
            $display("[sorted_priority_queue] ERROR");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("[sorted_priority_queue] ERROR");
        $finish;
    end

endmodule
